// File: rtl/wl1_pkg.sv
// ----------------------------------------------------------------------------
// wl1_pkg: shared types and constants
// Widths, config indexes and the pipeline sideband type of the weighted
// L1 nearest neighbor unit.
// ----------------------------------------------------------------------------
package wl1_pkg;

  localparam int MAX_DIMS         = 8;
  localparam int COMP_WIDTH       = 16;
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int WEIGHT_WIDTH     = 16;
  localparam int DIST_WIDTH       = 24;
  localparam int ID_WIDTH         = 64;
  localparam int CFG_DATA_WIDTH   = 64;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int DIMS_WIDTH       = 4;

  localparam int PROD_WIDTH = COMP_WIDTH + WEIGHT_WIDTH;
  localparam int PAIRS      = MAX_DIMS / 2;
  localparam int PAIR_WIDTH = PROD_WIDTH + 1;
  localparam int SUM_WIDTH  = PROD_WIDTH + $clog2(MAX_DIMS);

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;
  localparam logic [CFG_DATA_WIDTH-1:0] RECIP_RESET = 64'h1000_1000_1000_1000;
  localparam logic [DIMS_WIDTH-1:0] DIMS_RESET = DIMS_WIDTH'(MAX_DIMS);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RECIP_LOW  = 2'd0,
    CFG_RECIP_HIGH = 2'd1,
    CFG_DIMS       = 2'd2
  } cfg_index_e;

  typedef enum logic {
    FUNC_QUERY = 1'b0,
    FUNC_CAND  = 1'b1
  } func_e;

  // sideband that travels with a beat down the pipeline
  typedef struct packed {
    logic                  valid;
    func_e                 func;
    logic                  last;
    logic [ID_WIDTH-1:0]   id;
    logic [DIST_WIDTH-1:0] bound;
  } meta_t;

endpackage

// File: rtl/wl1_lane.sv
// ----------------------------------------------------------------------------
// wl1_lane: one dimension of the distance
// Absolute difference of candidate and query component times the
// reciprocal weight, registered.
// ----------------------------------------------------------------------------
module wl1_lane import wl1_pkg::*; (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  logic                         en_i,
  input  logic signed [COMP_WIDTH-1:0] comp_i,
  input  logic signed [COMP_WIDTH-1:0] query_i,
  input  logic [WEIGHT_WIDTH-1:0]      weight_i,
  output logic [PROD_WIDTH-1:0]        prod_o
);

  logic [COMP_WIDTH-1:0] a, b, diff;
  logic [PROD_WIDTH-1:0] prod_d, prod_q;

  // offset binary: unsigned order equals signed order
  assign a = {~comp_i[COMP_WIDTH-1], comp_i[COMP_WIDTH-2:0]};
  assign b = {~query_i[COMP_WIDTH-1], query_i[COMP_WIDTH-2:0]};

  always_comb begin
    diff   = (a > b) ? (a - b) : (b - a);
    prod_d = '0;
    if (en_i) begin
      prod_d = {{WEIGHT_WIDTH{1'b0}}, diff} * {{COMP_WIDTH{1'b0}}, weight_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/wl1_merge.sv
// ----------------------------------------------------------------------------
// wl1_merge: lane merge
// Two-stage adder tree over the lane products, then the fixed point
// shift and saturation to the distance width.
// ----------------------------------------------------------------------------
module wl1_merge import wl1_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [PROD_WIDTH-1:0] prod_i [MAX_DIMS],
  input  meta_t                 meta_i,
  output logic [DIST_WIDTH-1:0] dist_o,
  output meta_t                 meta_o
);

  logic [PAIR_WIDTH-1:0] pair_q [PAIRS];
  logic [SUM_WIDTH-1:0]  sum, shifted;
  logic [DIST_WIDTH-1:0] dist_d, dist_q;
  meta_t                 s2_meta_q, s3_meta_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int p = 0; p < PAIRS; p++) begin
        pair_q[p] <= PAIR_WIDTH'(prod_i[2*p]) + PAIR_WIDTH'(prod_i[2*p+1]);
      end
      dist_q <= dist_d;
    end
  end

  always_comb begin
    sum = '0;
    for (int p = 0; p < PAIRS; p++) begin
      sum = sum + SUM_WIDTH'(pair_q[p]);
    end
    shifted = sum >> WEIGHT_FRAC_BITS;
    dist_d  = (shifted > SUM_WIDTH'(DIST_MAX)) ? DIST_MAX : shifted[DIST_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_meta_q <= '0;
      s3_meta_q <= '0;
    end else if (adv_i) begin
      s2_meta_q <= meta_i;
      s3_meta_q <= s2_meta_q;
    end
  end

  assign dist_o = dist_q;
  assign meta_o = s3_meta_q;

endmodule

// File: rtl/wl1_best.sv
// ----------------------------------------------------------------------------
// wl1_best: running best and result register
// Keeps the smallest distance seen since the last query load and hands
// out the result beat on the last candidate of a group.
// ----------------------------------------------------------------------------
module wl1_best import wl1_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  meta_t                 meta_i,
  input  logic [DIST_WIDTH-1:0] dist_i,
  input  logic                  out_stall_i,
  output logic                  blocked_o,
  output logic                  out_valid_o,
  output logic                  found_o,
  output logic [ID_WIDTH-1:0]   best_id_o,
  output logic [DIST_WIDTH-1:0] best_distance_o
);

  logic [DIST_WIDTH-1:0] best_dist_d, best_dist_q;
  logic [ID_WIDTH-1:0]   best_id_d, best_id_q;
  logic                  found_d, found_q;
  logic                  out_valid_d, out_valid_q;
  logic                  found_out_q;
  logic [ID_WIDTH-1:0]   id_out_q;
  logic [DIST_WIDTH-1:0] dist_out_q;
  logic                  take, emit;

  // only a result beat that meets a full, stalled output holds the pipe
  assign blocked_o = meta_i.valid && (meta_i.func == FUNC_CAND) && meta_i.last &&
                     out_valid_q && out_stall_i;
  assign take = meta_i.valid && !blocked_o;
  assign emit = take && (meta_i.func == FUNC_CAND) && meta_i.last;

  always_comb begin
    best_dist_d = best_dist_q;
    best_id_d   = best_id_q;
    found_d     = found_q;
    if (take) begin
      if (meta_i.func == FUNC_QUERY) begin
        best_dist_d = meta_i.bound;
        best_id_d   = '0;
        found_d     = 1'b0;
      end else if (dist_i < best_dist_q) begin
        best_dist_d = dist_i;
        best_id_d   = meta_i.id;
        found_d     = 1'b1;
      end
    end
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DIST_MAX;
      best_id_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      best_dist_q <= best_dist_d;
      best_id_q   <= best_id_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_out_q <= found_d;
      id_out_q    <= found_d ? best_id_d : '0;
      dist_out_q  <= best_dist_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_out_q;
  assign best_id_o       = id_out_q;
  assign best_distance_o = dist_out_q;

endmodule

// File: rtl/weighted_l1_nearest_neighbor_unit.sv
// ----------------------------------------------------------------------------
// weighted_l1_nearest_neighbor_unit: weighted L1 nearest neighbor search
// Query beats load the query vector and bound, candidate beats are scored
// in eight parallel lanes and the best one is reported on the last beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  func, cand_id, comp_0..7, is_last,
//                                       start_bound
//  out      out  out_valid_o/out_stall_i found, best_id, best_distance
//  cfg      in   cfg_we_i               cfg_index_i, cfg_data_i
//
//  One beat per cycle while in_stall_o is low. Stages: lane multiply, pair sums,
//  final sum and saturation, running-best compare into the result register.
//  Query vector is written at accept, so a candidate may follow a query at once.
//  in_stall_o rises only when a last candidate reaches the compare stage
//  while the result register is full and stalled.
//  Reset: zero query, bound all ones, unity weights, eight dimensions.
// ----------------------------------------------------------------------------
module weighted_l1_nearest_neighbor_unit import wl1_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [ID_WIDTH-1:0]          cand_id_i,
  input  logic signed [COMP_WIDTH-1:0] comp_0_i,
  input  logic signed [COMP_WIDTH-1:0] comp_1_i,
  input  logic signed [COMP_WIDTH-1:0] comp_2_i,
  input  logic signed [COMP_WIDTH-1:0] comp_3_i,
  input  logic signed [COMP_WIDTH-1:0] comp_4_i,
  input  logic signed [COMP_WIDTH-1:0] comp_5_i,
  input  logic signed [COMP_WIDTH-1:0] comp_6_i,
  input  logic signed [COMP_WIDTH-1:0] comp_7_i,
  input  logic                         is_last_i,
  input  logic [DIST_WIDTH-1:0]        start_bound_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [ID_WIDTH-1:0]          best_id_o,
  output logic [DIST_WIDTH-1:0]        best_distance_o
);

  logic [CFG_DATA_WIDTH-1:0]   recip_low_q, recip_high_q;
  logic [DIMS_WIDTH-1:0]       dims_q;
  logic [2*CFG_DATA_WIDTH-1:0] recip_all;
  logic signed [COMP_WIDTH-1:0] comp [MAX_DIMS];
  logic signed [COMP_WIDTH-1:0] query_q [MAX_DIMS];
  logic [PROD_WIDTH-1:0]       prod [MAX_DIMS];
  logic [DIST_WIDTH-1:0]       cand_dist;
  meta_t                       s1_meta_d, s1_meta_q, s3_meta;
  logic                        blocked, adv, accept;

  assign adv        = !blocked;
  assign in_stall_o = blocked;
  assign accept     = in_valid_i && adv;

  assign comp[0] = comp_0_i;
  assign comp[1] = comp_1_i;
  assign comp[2] = comp_2_i;
  assign comp[3] = comp_3_i;
  assign comp[4] = comp_4_i;
  assign comp[5] = comp_5_i;
  assign comp[6] = comp_6_i;
  assign comp[7] = comp_7_i;

  assign recip_all = {recip_high_q, recip_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_low_q  <= RECIP_RESET;
      recip_high_q <= RECIP_RESET;
      dims_q       <= DIMS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RECIP_LOW:  recip_low_q  <= cfg_data_i;
        CFG_RECIP_HIGH: recip_high_q <= cfg_data_i;
        CFG_DIMS:       dims_q       <= cfg_data_i[DIMS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        query_q[d] <= '0;
      end
    end else if (accept && (func_e'(func_i) == FUNC_QUERY)) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        query_q[d] <= comp[d];
      end
    end
  end

  always_comb begin
    s1_meta_d.valid = accept;
    s1_meta_d.func  = func_e'(func_i);
    s1_meta_d.last  = is_last_i;
    s1_meta_d.id    = cand_id_i;
    s1_meta_d.bound = start_bound_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_meta_q <= '0;
    end else if (adv) begin
      s1_meta_q <= s1_meta_d;
    end
  end

  // dims above the lane count enable every lane
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    wl1_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .en_i     (dims_q > DIMS_WIDTH'(d)),
      .comp_i   (comp[d]),
      .query_i  (query_q[d]),
      .weight_i (recip_all[WEIGHT_WIDTH*d +: WEIGHT_WIDTH]),
      .prod_o   (prod[d])
    );
  end

  wl1_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .prod_i (prod),
    .meta_i (s1_meta_q),
    .dist_o (cand_dist),
    .meta_o (s3_meta)
  );

  wl1_best u_best (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .meta_i          (s3_meta),
    .dist_i          (cand_dist),
    .out_stall_i     (out_stall_i),
    .blocked_o       (blocked),
    .out_valid_o     (out_valid_o),
    .found_o         (found_o),
    .best_id_o       (best_id_o),
    .best_distance_o (best_distance_o)
  );

endmodule

// File: rtl/wl1_checker.sv
// ----------------------------------------------------------------------------
// wl1_checker: port-level checks
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module wl1_checker import wl1_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  found_o,
  input logic [ID_WIDTH-1:0]   best_id_o,
  input logic [DIST_WIDTH-1:0] best_distance_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(best_id_o) && $stable(best_distance_o))
    else $error("result beat changed while stalled");

  // input is held back only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_not_found_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_id_o == '0)
    else $error("nonzero id on a not-found result");

  // a winner beat a bound no larger than the maximum, so it is below it
  a_found_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> best_distance_o != DIST_MAX)
    else $error("found result with saturated distance");

endmodule

bind weighted_l1_nearest_neighbor_unit wl1_checker u_wl1_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .found_o         (found_o),
  .best_id_o       (best_id_o),
  .best_distance_o (best_distance_o)
);
